[rtl/pid_pkg.sv]
// Shared types and constants for the priority interrupt dispatcher.
package pid_pkg;

  localparam int PIN_W   = 21;
  localparam int CNT_W   = 10;
  localparam int SRC_W   = 4;
  localparam int PNUM_W  = 5;
  localparam int SEN_W   = 6;
  localparam int PER_W   = 24;
  localparam int TICK_W  = 32;
  localparam int COM_MAX = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CMD_QUEUE_DEPTH = 2;

  localparam logic [SRC_W-1:0] SRC_I2C_DONE = 4'd0;
  localparam logic [SRC_W-1:0] SRC_I2C_RX   = 4'd1;
  localparam logic [SRC_W-1:0] SRC_I2C_TX   = 4'd2;
  localparam logic [SRC_W-1:0] SRC_COM1     = 4'd3;
  localparam logic [SRC_W-1:0] SRC_PIN      = 4'd7;
  localparam logic [SRC_W-1:0] SRC_TICK     = 4'd8;

  localparam int SEN_I2C  = 0;
  localparam int SEN_COM1 = 1;
  localparam int SEN_TICK = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COM1_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COM2_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COM3_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COM4_LEVEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_ENABLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_RISING    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 3'd7;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_GRANT,
    CMD_TRYTICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SRC_W-1:0]  source;
    logic [PNUM_W-1:0] pin_number;
  } cmd_t;

  typedef struct packed {
    logic [SEN_W-1:0]             source_enable;
    logic [COM_MAX-1:0][CNT_W-1:0] com_level;
    logic [PIN_W-1:0]             pin_enable;
    logic [PIN_W-1:0]             pin_rising;
    logic [PER_W-1:0]             tick_period;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] c1;
    logic [CNT_W-1:0] c2;
    logic [CNT_W-1:0] c3;
    logic [CNT_W-1:0] c4;
  } com_counts_t;

endpackage

[rtl/pid_front.sv]
// Front end: accepts words and classifies each into a back-end command.
module pid_front #(
  parameter int PIN_COUNT    = 21,
  parameter int SERIAL_PORTS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pid_pkg::cfg_t             cfg,
  input  logic                      accept,
  input  logic                      op,
  input  logic                      in_handler,
  input  logic                      immediate_mode,
  input  logic                      i2c_done,
  input  logic                      i2c_rx_ready,
  input  logic                      i2c_tx_ready,
  input  pid_pkg::com_counts_t      counts,
  input  logic [pid_pkg::PIN_W-1:0] pin_levels,
  output pid_pkg::cmd_t             cmd
);
  import pid_pkg::*;

  localparam int NPINS = (PIN_COUNT < PIN_W) ? PIN_COUNT : PIN_W;
  localparam logic [PIN_W-1:0] PIN_MASK = PIN_W'((64'd1 << NPINS) - 64'd1);

  logic [PIN_W-1:0]   last_levels_r, last_levels_nxt;
  logic [PIN_W-1:0]   now, was, en, edges, upto, upd;
  logic [COM_MAX-1:0][CNT_W-1:0] cnt;
  logic [COM_MAX-1:0] com_hit;
  logic               pin_scan;
  logic [PNUM_W-1:0]  pin_idx;

  assign cnt = {counts.c4, counts.c3, counts.c2, counts.c1};
  assign now = pin_levels & PIN_MASK;
  assign was = last_levels_r;
  assign en  = cfg.pin_enable & PIN_MASK;
  assign edges = en & ((cfg.pin_rising & ~was & now) | (~cfg.pin_rising & was & ~now));
  assign upto  = edges ^ (edges - PIN_W'(1));
  assign upd   = en & upto;

  always_comb begin
    for (int p = 0; p < COM_MAX; p++) begin
      com_hit[p] = (p < SERIAL_PORTS) && cfg.source_enable[SEN_COM1 + p] &&
                   (cnt[p] >= cfg.com_level[p]);
    end
  end

  always_comb begin
    pin_idx = '0;
    for (int p = PIN_W - 1; p >= 0; p--) begin
      if (edges[p]) begin
        pin_idx = PNUM_W'(p);
      end
    end
  end

  always_comb begin
    cmd      = '{kind: CMD_NONE, source: SRC_I2C_DONE, pin_number: '0};
    pin_scan = 1'b0;
    if (!op) begin
      cmd.kind = CMD_TICK;
    end else if (in_handler || immediate_mode) begin
      cmd.kind = CMD_NONE;
    end else if (cfg.source_enable[SEN_I2C] && i2c_done) begin
      cmd.kind   = CMD_GRANT;
      cmd.source = SRC_I2C_DONE;
    end else if (i2c_rx_ready) begin
      cmd.kind   = CMD_GRANT;
      cmd.source = SRC_I2C_RX;
    end else if (i2c_tx_ready) begin
      cmd.kind   = CMD_GRANT;
      cmd.source = SRC_I2C_TX;
    end else if (com_hit[0]) begin
      cmd.kind   = CMD_GRANT;
      cmd.source = SRC_COM1;
    end else if (com_hit[1]) begin
      cmd.kind   = CMD_GRANT;
      cmd.source = SRC_COM1 + SRC_W'(1);
    end else if (com_hit[2]) begin
      cmd.kind   = CMD_GRANT;
      cmd.source = SRC_COM1 + SRC_W'(2);
    end else if (com_hit[3]) begin
      cmd.kind   = CMD_GRANT;
      cmd.source = SRC_COM1 + SRC_W'(3);
    end else begin
      pin_scan = 1'b1;
      if (|edges) begin
        cmd.kind       = CMD_GRANT;
        cmd.source     = SRC_PIN;
        cmd.pin_number = pin_idx;
      end else begin
        cmd.kind = CMD_TRYTICK;
      end
    end
  end

  always_comb begin
    last_levels_nxt = last_levels_r;
    if (accept && pin_scan) begin
      last_levels_nxt = (last_levels_r & ~upd) | (now & upd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_levels_r <= '0;
    end else begin
      last_levels_r <= last_levels_nxt;
    end
  end

endmodule

[rtl/pid_queue.sv]
// Short command queue between front and back ends.
module pid_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pid_pkg::cmd_t push_cmd,
  input  logic          pop,
  output pid_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);
  import pid_pkg::*;

  localparam int DEPTH = CMD_QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign head      = slot_r[rd_ptr_r];
  assign not_empty = (fill_r != '0);
  assign full      = (fill_r == CNT_W'(DEPTH));

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? advance(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? advance(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

[rtl/pid_mod.sv]
// Bit-serial remainder unit for the tick count, one quotient bit per cycle.
module pid_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pid_pkg::TICK_W-1:0] dividend,
  input  logic [pid_pkg::PER_W-1:0]  divisor,
  output logic                       done,
  output logic [pid_pkg::PER_W-1:0]  rem
);
  import pid_pkg::*;

  localparam int STEP_W = $clog2(TICK_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TICK_W-1:0] dvd_r, dvd_nxt;
  logic [PER_W-1:0]  dsr_r, dsr_nxt;
  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [PER_W:0]    trial;

  assign trial = {rem_r, dvd_r[TICK_W-1]};
  assign done  = done_r;
  assign rem   = rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = PER_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[PER_W-1:0];
      end
      dvd_nxt  = {dvd_r[TICK_W-2:0], 1'b0};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(TICK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

[rtl/pid_back.sv]
// Back end: tick counter, tick grant with period wrap, and output register.
module pid_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pid_pkg::cfg_t                cfg,
  input  logic                         tick_clear,
  input  logic                         q_valid,
  input  pid_pkg::cmd_t                q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_fired,
  output logic [pid_pkg::SRC_W-1:0]    out_source,
  output logic [pid_pkg::PNUM_W-1:0]   out_pin_number
);
  import pid_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [TICK_W-1:0] count_r, count_nxt;
  logic              res_fired_r, res_fired_nxt;
  logic [SRC_W-1:0]  res_src_r, res_src_nxt;
  logic [PNUM_W-1:0] res_pin_r, res_pin_nxt;
  logic              ov_r, ov_nxt;
  logic              of_r, of_nxt;
  logic [SRC_W-1:0]  os_r, os_nxt;
  logic [PNUM_W-1:0] op_r, op_nxt;
  logic              tick_hit, div_start, div_done;
  logic [PER_W-1:0]  div_rem;

  assign tick_hit = cfg.source_enable[SEN_TICK] &&
                    (count_r > TICK_W'(cfg.tick_period));

  pid_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (count_r - TICK_W'(1)),
    .divisor  (cfg.tick_period),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign out_valid      = ov_r;
  assign out_fired      = of_r;
  assign out_source     = os_r;
  assign out_pin_number = op_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    res_fired_nxt = res_fired_r;
    res_src_nxt   = res_src_r;
    res_pin_nxt   = res_pin_r;
    ov_nxt        = ov_r;
    of_nxt        = of_r;
    os_nxt        = os_r;
    op_nxt        = op_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          res_fired_nxt = 1'b0;
          res_src_nxt   = SRC_I2C_DONE;
          res_pin_nxt   = '0;
          state_nxt     = ST_EMIT;
          case (q_head.kind)
            CMD_TICK: begin
              if (count_r != '1) begin
                count_nxt = count_r + TICK_W'(1);
              end
            end
            CMD_GRANT: begin
              res_fired_nxt = 1'b1;
              res_src_nxt   = q_head.source;
              res_pin_nxt   = q_head.pin_number;
            end
            CMD_TRYTICK: begin
              if (tick_hit) begin
                res_fired_nxt = 1'b1;
                res_src_nxt   = SRC_TICK;
                if (cfg.tick_period == '0) begin
                  count_nxt = '0;
                end else begin
                  div_start = 1'b1;
                  state_nxt = ST_DIV;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          count_nxt = TICK_W'(div_rem) + TICK_W'(1);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          of_nxt    = res_fired_r;
          os_nxt    = res_src_r;
          op_nxt    = res_pin_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (tick_clear) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    res_fired_r <= res_fired_nxt;
    res_src_r   <= res_src_nxt;
    res_pin_r   <= res_pin_nxt;
    of_r        <= of_nxt;
    os_r        <= os_nxt;
    op_r        <= op_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

[rtl/priority_interrupt_dispatcher_unit.sv]
// Priority interrupt dispatcher: top level with configuration registers.
//
// Input channel (in_valid/in_stall) takes one word per tick or poll; the
// result channel (out_valid/out_stall) returns exactly one word per input
// word, in order. A tick bumps the saturating tick count; a poll grants at
// most one source in fixed priority and reports fired, source and pin.
// A poll that grants the tick with a nonzero period first runs the
// bit-serial remainder of the tick count, one bit per cycle. The back end's
// sequencer handles one word at a time: it pops a word, runs the remainder
// when needed and emits the result before it pops the next.
// A two-word command queue lets the front keep accepting while the back is
// busy or the receiver stalls; in_stall rises only when that queue is full.
// A stalled result holds on the output ports until taken.
// Reset (rst_n low, synchronous) clears the queue, tick count and stored
// pin levels and returns the registers to their reset values. The user
// must write configuration with cfg_we, cfg_index and cfg_data while the
// block is idle; the block itself does not enforce this.
module priority_interrupt_dispatcher_unit #(
  parameter int PIN_COUNT    = 21,
  parameter int SERIAL_PORTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic                              in_in_handler,
  input  logic                              in_immediate_mode,
  input  logic                              in_i2c_done,
  input  logic                              in_i2c_rx_ready,
  input  logic                              in_i2c_tx_ready,
  input  logic [pid_pkg::CNT_W-1:0]         in_com1_count,
  input  logic [pid_pkg::CNT_W-1:0]         in_com2_count,
  input  logic [pid_pkg::CNT_W-1:0]         in_com3_count,
  input  logic [pid_pkg::CNT_W-1:0]         in_com4_count,
  input  logic [pid_pkg::PIN_W-1:0]         in_pin_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_fired,
  output logic [pid_pkg::SRC_W-1:0]         out_source,
  output logic [pid_pkg::PNUM_W-1:0]        out_pin_number
);
  import pid_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        tick_clear;
  logic        in_accept;
  cmd_t        front_cmd, q_head;
  logic        q_valid, q_full, q_pop;
  com_counts_t counts;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;
  assign counts    = '{c1: in_com1_count, c2: in_com2_count,
                       c3: in_com3_count, c4: in_com4_count};

  always_comb begin
    cfg_nxt    = cfg_r;
    tick_clear = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_ENABLE: cfg_nxt.source_enable = cfg_data[SEN_W-1:0];
        CFG_COM1_LEVEL:    cfg_nxt.com_level[0]  = cfg_data[CNT_W-1:0];
        CFG_COM2_LEVEL:    cfg_nxt.com_level[1]  = cfg_data[CNT_W-1:0];
        CFG_COM3_LEVEL:    cfg_nxt.com_level[2]  = cfg_data[CNT_W-1:0];
        CFG_COM4_LEVEL:    cfg_nxt.com_level[3]  = cfg_data[CNT_W-1:0];
        CFG_PIN_ENABLE:    cfg_nxt.pin_enable    = cfg_data[PIN_W-1:0];
        CFG_PIN_RISING:    cfg_nxt.pin_rising    = cfg_data[PIN_W-1:0];
        CFG_TICK_PERIOD: begin
          cfg_nxt.tick_period = cfg_data[PER_W-1:0];
          tick_clear          = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_enable <= '0;
      for (int k = 0; k < COM_MAX; k++) begin
        cfg_r.com_level[k] <= CNT_W'(1);
      end
      cfg_r.pin_enable  <= '0;
      cfg_r.pin_rising  <= '0;
      cfg_r.tick_period <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pid_front #(
    .PIN_COUNT    (PIN_COUNT),
    .SERIAL_PORTS (SERIAL_PORTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .accept         (in_accept),
    .op             (in_op),
    .in_handler     (in_in_handler),
    .immediate_mode (in_immediate_mode),
    .i2c_done       (in_i2c_done),
    .i2c_rx_ready   (in_i2c_rx_ready),
    .i2c_tx_ready   (in_i2c_tx_ready),
    .counts         (counts),
    .pin_levels     (in_pin_levels),
    .cmd            (front_cmd)
  );

  pid_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  pid_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .tick_clear     (tick_clear),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fired      (out_fired),
    .out_source     (out_source),
    .out_pin_number (out_pin_number)
  );

endmodule

[tb/pid_grant_checker.sv]
// Grant predictor and result checker for the priority interrupt dispatcher.
`timescale 1ns / 100ps

module pid_grant_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_op,
  input  logic                            in_in_handler,
  input  logic                            in_immediate_mode,
  input  logic                            in_i2c_done,
  input  logic                            in_i2c_rx_ready,
  input  logic                            in_i2c_tx_ready,
  input  logic [pid_pkg::CNT_W-1:0]       in_com1_count,
  input  logic [pid_pkg::CNT_W-1:0]       in_com2_count,
  input  logic [pid_pkg::CNT_W-1:0]       in_com3_count,
  input  logic [pid_pkg::CNT_W-1:0]       in_com4_count,
  input  logic [pid_pkg::PIN_W-1:0]       in_pin_levels,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_fired,
  input  logic [pid_pkg::SRC_W-1:0]       out_source,
  input  logic [pid_pkg::PNUM_W-1:0]      out_pin_number,
  output int                              fail_count,
  output int                              pending
);
  import pid_pkg::*;

  typedef struct packed {
    logic              fired;
    logic [SRC_W-1:0]  source;
    logic [PNUM_W-1:0] pin;
  } grant_t;

  logic [SEN_W-1:0]              src_en;
  logic [COM_MAX-1:0][CNT_W-1:0] com_lv;
  logic [PIN_W-1:0]              pin_en;
  logic [PIN_W-1:0]              pin_rise;
  logic [PER_W-1:0]              period;
  logic [PIN_W-1:0]              last_lv;
  logic [TICK_W-1:0]             tick_cnt;
  grant_t                        grant_q[$];

  function automatic grant_t dispatch_word(
    input logic                          op,
    input logic                          busy,
    input logic                          imm,
    input logic                          done,
    input logic                          rx,
    input logic                          tx,
    input logic [COM_MAX-1:0][CNT_W-1:0] cnt,
    input logic [PIN_W-1:0]              levels
  );
    grant_t g;
    logic   now_b;
    logic   was_b;
    logic   hit;
    g = '0;
    if (!op) begin
      if (tick_cnt != '1) tick_cnt = tick_cnt + TICK_W'(1);
      return g;
    end
    if (busy || imm) return g;
    g.fired = 1'b1;
    if (src_en[SEN_I2C] && done) begin
      g.source = SRC_I2C_DONE;
      return g;
    end
    if (rx) begin
      g.source = SRC_I2C_RX;
      return g;
    end
    if (tx) begin
      g.source = SRC_I2C_TX;
      return g;
    end
    for (int p = 0; p < COM_MAX; p++) begin
      if (src_en[SEN_COM1 + p] && cnt[p] >= com_lv[p]) begin
        g.source = SRC_COM1 + SRC_W'(p);
        return g;
      end
    end
    // store levels of enabled pins up to the granted one
    for (int p = 0; p < PIN_W; p++) begin
      if (pin_en[p]) begin
        now_b = levels[p];
        was_b = last_lv[p];
        hit = pin_rise[p] ? (!was_b && now_b) : (was_b && !now_b);
        last_lv[p] = now_b;
        if (hit) begin
          g.source = SRC_PIN;
          g.pin = PNUM_W'(p);
          return g;
        end
      end
    end
    if (src_en[SEN_TICK] && tick_cnt > TICK_W'(period)) begin
      if (period == '0) tick_cnt = '0;
      else tick_cnt = ((tick_cnt - TICK_W'(1)) % TICK_W'(period)) + TICK_W'(1);
      g.source = SRC_TICK;
      return g;
    end
    g.fired = 1'b0;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst_n) begin
      src_en = '0;
      for (int p = 0; p < COM_MAX; p++) com_lv[p] = CNT_W'(1);
      pin_en = '0;
      pin_rise = '0;
      period = '0;
      last_lv = '0;
      tick_cnt = '0;
      grant_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_ENABLE: src_en = cfg_data[SEN_W-1:0];
          CFG_COM1_LEVEL:    com_lv[0] = cfg_data[CNT_W-1:0];
          CFG_COM2_LEVEL:    com_lv[1] = cfg_data[CNT_W-1:0];
          CFG_COM3_LEVEL:    com_lv[2] = cfg_data[CNT_W-1:0];
          CFG_COM4_LEVEL:    com_lv[3] = cfg_data[CNT_W-1:0];
          CFG_PIN_ENABLE:    pin_en = cfg_data[PIN_W-1:0];
          CFG_PIN_RISING:    pin_rise = cfg_data[PIN_W-1:0];
          CFG_TICK_PERIOD: begin
            period = cfg_data[PER_W-1:0];
            tick_cnt = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        grant_q.push_back(dispatch_word(in_op, in_in_handler, in_immediate_mode,
          in_i2c_done, in_i2c_rx_ready, in_i2c_tx_ready,
          {in_com4_count, in_com3_count, in_com2_count, in_com1_count}, in_pin_levels));
      end
      if (out_valid && !out_stall) begin
        got = {out_fired, out_source, out_pin_number};
        if (grant_q.size() == 0) begin
          $display("%0t: expected no word, got fired %0d source %0d pin %0d",
                   $time, got.fired, got.source, got.pin);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected fired %0d source %0d pin %0d, got fired %0d source %0d pin %0d",
                     $time, want.fired, want.source, want.pin, got.fired, got.source, got.pin);
            fail_count++;
          end
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

[tb/priority_interrupt_dispatcher_unit_tb.sv]
// Stimulus and verdict for the priority interrupt dispatcher regression.
`timescale 1ns / 100ps

module priority_interrupt_dispatcher_unit_tb;
  import pid_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic                  in_in_handler;
  logic                  in_immediate_mode;
  logic                  in_i2c_done;
  logic                  in_i2c_rx_ready;
  logic                  in_i2c_tx_ready;
  logic [CNT_W-1:0]      in_com1_count;
  logic [CNT_W-1:0]      in_com2_count;
  logic [CNT_W-1:0]      in_com3_count;
  logic [CNT_W-1:0]      in_com4_count;
  logic [PIN_W-1:0]      in_pin_levels;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_fired;
  logic [SRC_W-1:0]      out_source;
  logic [PNUM_W-1:0]     out_pin_number;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int squeeze_req;
  int hold_left;
  int lv_now[COM_MAX];

  priority_interrupt_dispatcher_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_in_handler    (in_in_handler),
    .in_immediate_mode(in_immediate_mode),
    .in_i2c_done      (in_i2c_done),
    .in_i2c_rx_ready  (in_i2c_rx_ready),
    .in_i2c_tx_ready  (in_i2c_tx_ready),
    .in_com1_count    (in_com1_count),
    .in_com2_count    (in_com2_count),
    .in_com3_count    (in_com3_count),
    .in_com4_count    (in_com4_count),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired        (out_fired),
    .out_source       (out_source),
    .out_pin_number   (out_pin_number)
  );

  pid_grant_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_in_handler    (in_in_handler),
    .in_immediate_mode(in_immediate_mode),
    .in_i2c_done      (in_i2c_done),
    .in_i2c_rx_ready  (in_i2c_rx_ready),
    .in_i2c_tx_ready  (in_i2c_tx_ready),
    .in_com1_count    (in_com1_count),
    .in_com2_count    (in_com2_count),
    .in_com3_count    (in_com3_count),
    .in_com4_count    (in_com4_count),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired        (out_fired),
    .out_source       (out_source),
    .out_pin_number   (out_pin_number),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hold the receiver off for a long stretch on request
  always @(negedge clk) begin
    if (squeeze_req > 0) begin
      hold_left = squeeze_req;
      squeeze_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #6_000_000;
    $display("priority_interrupt_dispatcher_unit regression: fail");
    $finish;
  end

  task automatic issue(
    input logic                          op,
    input logic                          busy,
    input logic                          imm,
    input logic                          done,
    input logic                          rx,
    input logic                          tx,
    input logic [COM_MAX-1:0][CNT_W-1:0] cnt,
    input logic [PIN_W-1:0]              levels
  );
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_op             <= op;
    in_in_handler     <= busy;
    in_immediate_mode <= imm;
    in_i2c_done       <= done;
    in_i2c_rx_ready   <= rx;
    in_i2c_tx_ready   <= tx;
    in_com1_count     <= cnt[0];
    in_com2_count     <= cnt[1];
    in_com3_count     <= cnt[2];
    in_com4_count     <= cnt[3];
    in_pin_levels     <= levels;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic write_all(
    input logic [SEN_W-1:0]              sen,
    input logic [COM_MAX-1:0][CNT_W-1:0] lv,
    input logic [PIN_W-1:0]              pen,
    input logic [PIN_W-1:0]              prise,
    input logic [PER_W-1:0]              per
  );
    write_reg(CFG_SOURCE_ENABLE, CFG_DATA_W'(sen));
    write_reg(CFG_COM1_LEVEL, CFG_DATA_W'(lv[0]));
    write_reg(CFG_COM2_LEVEL, CFG_DATA_W'(lv[1]));
    write_reg(CFG_COM3_LEVEL, CFG_DATA_W'(lv[2]));
    write_reg(CFG_COM4_LEVEL, CFG_DATA_W'(lv[3]));
    write_reg(CFG_PIN_ENABLE, CFG_DATA_W'(pen));
    write_reg(CFG_PIN_RISING, CFG_DATA_W'(prise));
    write_reg(CFG_TICK_PERIOD, CFG_DATA_W'(per));
    cfg_we <= 1'b0;
    for (int p = 0; p < COM_MAX; p++) lv_now[p] = int'(lv[p]);
  endtask

  initial begin
    logic [SEN_W-1:0]              sen;
    logic [COM_MAX-1:0][CNT_W-1:0] lvc;
    logic [COM_MAX-1:0][CNT_W-1:0] cnt;
    logic [PIN_W-1:0]              pen;
    logic [PIN_W-1:0]              prise;
    logic [PIN_W-1:0]              pins;
    logic [PER_W-1:0]              per;
    logic                          deep;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_op = 1'b0;
    in_in_handler = 1'b0;
    in_immediate_mode = 1'b0;
    in_i2c_done = 1'b0;
    in_i2c_rx_ready = 1'b0;
    in_i2c_tx_ready = 1'b0;
    in_com1_count = '0;
    in_com2_count = '0;
    in_com3_count = '0;
    in_com4_count = '0;
    in_pin_levels = '0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    for (int p = 0; p < COM_MAX; p++) lv_now[p] = 1;
    pins = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: everything but the I2C rx and tx ready flags is masked
    issue(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    issue(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0, '0);
    issue(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, {4{10'h3FF}}, '1);
    drain();
    write_all(6'h3F, {10'd8, 10'd7, 10'd6, 10'd5}, '1, 21'h0AAAAA, 24'd2);
    issue(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, {10'd7, 10'd6, 10'd5, 10'd5}, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, {10'd7, 10'd6, 10'd6, 10'd4}, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, {10'd7, 10'd7, 10'd5, 10'd4}, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, {10'h3FF, 10'd6, 10'd5, 10'd4}, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '1);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '1);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    repeat (3) issue(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    repeat (3) issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    drain();
    write_reg(CFG_TICK_PERIOD, '0);
    cfg_we <= 1'b0;
    issue(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);
    issue(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 0) begin
        sen = '1;
        lvc = {4{10'h3FF}};
        pen = '1;
        prise = '1;
        per = '1;
      end else if (ph == 1) begin
        sen = '0;
        lvc = '0;
        pen = '0;
        prise = '0;
        per = '0;
      end else begin
        sen = SEN_W'($urandom_range(0, 63));
        if ($urandom_range(0, 9) < 7) sen[SEN_TICK] = 1'b1;
        for (int p = 0; p < COM_MAX; p++) begin
          case ($urandom_range(0, 3))
            0: lvc[p] = '0;
            1: lvc[p] = '1;
            2: lvc[p] = CNT_W'($urandom_range(1, 16));
            default: lvc[p] = CNT_W'($urandom_range(0, 1023));
          endcase
        end
        pen = PIN_W'($urandom);
        prise = PIN_W'($urandom);
        case ($urandom_range(0, 4))
          0: per = '0;
          1: per = PER_W'($urandom);
          default: per = PER_W'($urandom_range(1, 10));
        endcase
      end
      write_all(sen, lvc, pen, prise, per);
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 53;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 53;
        end
        default: begin
          idle_pct = 7;
          stall_pct = 7;
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        if (ph == 4 && n == 50) squeeze_req = 80;
        deep = 1'($urandom_range(0, 1));
        for (int p = 0; p < COM_MAX; p++) begin
          if (deep) begin
            cnt[p] = (lv_now[p] == 0) ? '0 : CNT_W'($urandom_range(0, lv_now[p] - 1));
          end else begin
            case ($urandom_range(0, 3))
              0: cnt[p] = CNT_W'(lv_now[p]);
              1: cnt[p] = '1;
              2: cnt[p] = '0;
              default: cnt[p] = CNT_W'($urandom_range(0, 1023));
            endcase
          end
        end
        if ($urandom_range(0, 9) == 0) pins = PIN_W'($urandom);
        else pins[PNUM_W'($urandom_range(0, PIN_W - 1))] ^= 1'b1;
        if ($urandom_range(0, 2) == 0) pins[PNUM_W'($urandom_range(0, PIN_W - 1))] ^= 1'b1;
        issue($urandom_range(0, 99) >= 40, $urandom_range(0, 9) == 0,
              $urandom_range(0, 9) == 0,
              !deep && $urandom_range(0, 5) == 0, !deep && $urandom_range(0, 5) == 0,
              !deep && $urandom_range(0, 5) == 0, cnt, pins);
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("priority_interrupt_dispatcher_unit regression: pass");
    end else begin
      $display("priority_interrupt_dispatcher_unit regression: fail");
    end
    $finish;
  end

endmodule

[priority_interrupt_dispatcher_unit.f]
rtl/pid_pkg.sv
rtl/pid_front.sv
rtl/pid_queue.sv
rtl/pid_mod.sv
rtl/pid_back.sv
rtl/priority_interrupt_dispatcher_unit.sv
tb/pid_grant_checker.sv
tb/priority_interrupt_dispatcher_unit_tb.sv
